@@ sv/swks_pkg.sv @@
// shared constants and types for the sliding-window k-smallest sum filter
package swks_pkg;

	// sizing
	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS    = 22;
	localparam int CFG_BITS    = 7;
	localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int PTR_BITS    = $clog2(MAX_WINDOW);
	localparam int CMP_BITS    = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
	localparam int TREE_LEVELS = $clog2(MAX_WINDOW);
	localparam int TREE_N      = 1 << TREE_LEVELS;

	// register port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_WINDOW_LEN = 1'b0;
	localparam logic REG_KEEP_COUNT = 1'b1;
	localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = 7'd64;
	localparam logic [CFG_BITS-1:0] KEEP_COUNT_RESET = 7'd1;

	// one stored entry of the sorted chain
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] val;
		logic                   vld;
	} slot_t;

	// what a cell hands to its right-hand neighbour
	typedef struct packed {
		slot_t b;   // entry after removal, before insertion
		logic  le;  // that entry is valid and not above the new sample
	} link_t;

	// broadcast to every cell
	typedef struct packed {
		logic                   upd;  // a word is taken this cycle
		logic                   clr;  // window emptied before the word
		logic                   rem;  // window full, oldest leaves
		logic [SAMPLE_BITS-1:0] v;    // incoming sample
		logic [SAMPLE_BITS-1:0] r;    // value of the oldest sample
	} cell_ctl_t;

endpackage

@@ sv/sliding_window_k_smallest_sum.sv @@
// top level: sorted cell chain, arrival ring and registered adder tree
//
// Order-statistic window filter. Each input word (sample, restart) enters the
// window; once window_len samples are held, every word yields one output word
// window_sum, the sum of the keep_count smallest samples in the window. While
// the window is filling no output word is given. restart empties the window
// before its own sample is taken; writing window_len empties it too.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Throughput: one word per cycle unless a held result stalls. The chain of
// compare-and-shift cells removes the oldest sample and inserts the new one
// in the same cycle; the oldest value is prefetched from the arrival ring
// every cycle. out_valid is carried by result flags that run along the
// registered adder tree over the cells.
// When out_stall holds a result, the whole pipeline freezes and in_stall rises
// in the same cycle; nothing is lost or repeated.
// Reset empties the window (no clearing pass is needed), sets window_len to 64
// and keep_count to 1. The user must write registers over the APB-style port
// only while the block is idle; the block itself does not enforce this.
module sliding_window_k_smallest_sum
	import swks_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   restart,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SUM_BITS-1:0]    window_sum,
	// register port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [DATA_BITS-1:0]   pwdata,
	output logic [DATA_BITS-1:0]   prdata,
	output logic                   pready
);

	localparam int SLOT_W = LEN_BITS + 1;

	logic [CFG_BITS-1:0]    len_q;
	logic [CFG_BITS-1:0]    keep_q;
	logic                   clr_pend_q;
	logic [LEN_BITS-1:0]    fill_q;
	logic [PTR_BITS-1:0]    op_q;
	logic [SAMPLE_BITS-1:0] ring_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] oldest_q;
	logic [LEN_BITS-1:0]    len_eff;
	logic [LEN_BITS-1:0]    k_eff;
	logic                   adv;
	logic                   accept;
	logic                   cfg_wr;
	logic                   clr;
	logic [LEN_BITS-1:0]    fill_c;
	logic [PTR_BITS-1:0]    op_c;
	logic [PTR_BITS-1:0]    op_inc;
	logic                   full;
	logic [PTR_BITS-1:0]    op_n;
	logic [LEN_BITS-1:0]    fill_n;
	logic [SLOT_W-1:0]      slot_sum;
	logic [PTR_BITS-1:0]    wr_addr;
	logic [PTR_BITS-1:0]    rd_addr;
	logic                   result;
	cell_ctl_t              ctl;
	slot_t                  stored [MAX_WINDOW];
	link_t                  link [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  vld_vec;
	logic [SUM_BITS-1:0]    leaf [TREE_N];
	logic [SUM_BITS-1:0]    node_q [TREE_N-1];
	logic                   lvl_q [TREE_LEVELS+1];

	// effective window length and keep count
	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (CMP_BITS'(len_q) > CMP_BITS'(MAX_WINDOW)) begin
			len_eff = LEN_BITS'(MAX_WINDOW);
		end else begin
			len_eff = LEN_BITS'(len_q);
		end
		if (CMP_BITS'(keep_q) > CMP_BITS'(len_eff)) begin
			k_eff = len_eff;
		end else begin
			k_eff = LEN_BITS'(keep_q);
		end
	end

	// handshake: a held result freezes the whole pipeline
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// fill count, oldest pointer and ring slot for this word
	always_comb begin
		clr    = restart | clr_pend_q;
		fill_c = clr ? '0 : fill_q;
		op_c   = clr ? '0 : op_q;
		full   = (fill_c >= len_eff);
		op_inc = (op_c == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : op_c + 1'b1;
		op_n   = full ? op_inc : op_c;
		fill_n = full ? fill_c : fill_c + 1'b1;
		slot_sum = SLOT_W'(op_n) + SLOT_W'(fill_n) - SLOT_W'(1);
		if (slot_sum >= SLOT_W'(MAX_WINDOW)) begin
			slot_sum = slot_sum - SLOT_W'(MAX_WINDOW);
		end
		wr_addr = PTR_BITS'(slot_sum);
		rd_addr = accept ? op_n : op_q;
		result  = (fill_n == len_eff);
	end

	// arrival ring with registered read of the next oldest sample
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q[wr_addr] <= sample;
		end
		if (accept && (wr_addr == rd_addr)) begin
			oldest_q <= sample;
		end else begin
			oldest_q <= ring_q[rd_addr];
		end
	end

	// control state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= WINDOW_LEN_RESET;
			keep_q     <= KEEP_COUNT_RESET;
			clr_pend_q <= 1'b0;
			fill_q     <= '0;
			op_q       <= '0;
		end else begin
			if (accept) begin
				fill_q     <= fill_n;
				op_q       <= op_n;
				clr_pend_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[2])
					REG_WINDOW_LEN: begin
						len_q      <= pwdata[CFG_BITS-1:0];
						clr_pend_q <= 1'b1;
					end
					REG_KEEP_COUNT: begin
						keep_q <= pwdata[CFG_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// register read back
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_WINDOW_LEN: prdata = DATA_BITS'(len_q);
			REG_KEEP_COUNT: prdata = DATA_BITS'(keep_q);
			default:        prdata = '0;
		endcase
	end

	// broadcast to the cells
	assign ctl.upd = accept;
	assign ctl.clr = clr;
	assign ctl.rem = full;
	assign ctl.v   = sample;
	assign ctl.r   = oldest_q;

	// sorted chain of cells, smallest at index zero
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		slot_t right_w;
		link_t left_w;
		if (i == MAX_WINDOW - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid
			assign right_w = stored[i+1];
		end
		if (i == 0) begin : g_first
			assign left_w.b  = '0;
			assign left_w.le = 1'b1;
		end else begin : g_rest
			assign left_w = link[i-1];
		end
		swks_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.right_in (right_w),
			.left_in  (left_w),
			.self_out (stored[i]),
			.link_out (link[i])
		);
		assign vld_vec[i] = stored[i].vld;
	end

	// tree leaves: cells below the keep count, others add nothing
	for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
		if (i < MAX_WINDOW) begin : g_used
			assign leaf[i] = (stored[i].vld && (LEN_BITS'(i) < k_eff)) ?
				SUM_BITS'(stored[i].val) : '0;
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	// registered adder tree, node j has children 2j+1 and 2j+2
	for (genvar j = 0; j < TREE_N - 1; j++) begin : g_node
		logic [SUM_BITS-1:0] lhs;
		logic [SUM_BITS-1:0] rhs;
		if (2 * j + 1 >= TREE_N - 1) begin : g_leaves
			assign lhs = leaf[2*j+1-(TREE_N-1)];
			assign rhs = leaf[2*j+2-(TREE_N-1)];
		end else begin : g_inner
			assign lhs = node_q[2*j+1];
			assign rhs = node_q[2*j+2];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				node_q[j] <= lhs + rhs;
			end
		end
	end

	// result flags along the tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= TREE_LEVELS; s++) begin
				lvl_q[s] <= 1'b0;
			end
		end else if (adv) begin
			lvl_q[0] <= accept && result;
			for (int s = 1; s <= TREE_LEVELS; s++) begin
				lvl_q[s] <= lvl_q[s-1];
			end
		end
	end

	assign out_valid  = lvl_q[TREE_LEVELS];
	assign window_sum = node_q[0];

	// chain occupancy matches the fill count
	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(fill_q))
		else $error("cell occupancy differs from fill count");

	// occupied cells are packed at the low end
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_vec & (vld_vec + 1'b1)) == '0)
		else $error("gap in the cell chain");

	// chain stays in ascending order
	for (genvar i = 0; i < MAX_WINDOW - 1; i++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			stored[i+1].vld |-> (stored[i].vld && (stored[i].val <= stored[i+1].val)))
			else $error("cell chain out of order");
	end

	// input is held back only by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

endmodule

@@ sv/swks_cell.sv @@
// one compare-and-shift cell of the sorted window chain
module swks_cell
	import swks_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  slot_t     right_in,
	input  link_t     left_in,
	output slot_t     self_out,
	output link_t     link_out
);

	logic [SAMPLE_BITS-1:0] val_q;
	logic                   vld_q;
	logic                   a_vld;
	logic                   ra_vld;
	logic                   shift;
	slot_t                  b;
	logic                   le;
	slot_t                  nxt;

	// removal: the first entry equal to the oldest value and all after it move left
	always_comb begin
		a_vld  = vld_q & ~ctl.clr;
		ra_vld = right_in.vld & ~ctl.clr;
		shift  = ctl.rem & (~a_vld | (val_q >= ctl.r));
		if (shift) begin
			b.val = right_in.val;
			b.vld = ra_vld;
		end else begin
			b.val = val_q;
			b.vld = a_vld;
		end
		le = b.vld & (b.val <= ctl.v);
	end

	// insertion: new sample lands after all entries not above it
	always_comb begin
		if (le) begin
			nxt = b;
		end else if (left_in.le) begin
			nxt.val = ctl.v;
			nxt.vld = 1'b1;
		end else begin
			nxt = left_in.b;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.upd) begin
			vld_q <= nxt.vld;
		end
	end

	// sample value
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			val_q <= nxt.val;
		end
	end

	assign self_out.val = val_q;
	assign self_out.vld = vld_q;
	assign link_out.b   = b;
	assign link_out.le  = le;

endmodule

@@ sim/swks_checker.sv @@
// channel monitor, window predictor and result checker for the k-smallest sum filter
module swks_checker
	import swks_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   restart,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [SUM_BITS-1:0]    window_sum,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [DATA_BITS-1:0]   pwdata,
	input  logic [DATA_BITS-1:0]   prdata,
	input  logic                   pready,
	output int                     mismatches,
	output int                     outstanding,
	output int                     sums_checked
);

	localparam logic [ADDR_BITS-1:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
	localparam logic [ADDR_BITS-1:0] ADDR_KEEP_COUNT = {REG_KEEP_COUNT, 2'b00};

	// shadow of the window in arrival order and in ascending order
	logic [SAMPLE_BITS-1:0] arrivals [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] ascending [MAX_WINDOW];
	int                     held;
	int                     oldest;
	logic [CFG_BITS-1:0]    window_len_reg;
	logic [CFG_BITS-1:0]    keep_count_reg;
	logic [SUM_BITS-1:0]    expected_sums [$];

	initial begin
		mismatches   = 0;
		sums_checked = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// zero acts as one, anything above the store saturates
	function automatic int live_window();
		if (window_len_reg == '0)
			return 1;
		if (window_len_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return int'(window_len_reg);
	endfunction

	// slide the window by one sample and queue the sum it yields, if any
	task automatic slide_window(input logic [SAMPLE_BITS-1:0] s, input logic rs);
		int                 len;
		int                 pos;
		int                 i;
		int                 k;
		logic [SAMPLE_BITS-1:0] leaving;
		logic [SUM_BITS+15:0]   total;
		len = live_window();
		if (rs) begin
			held   = 0;
			oldest = 0;
		end
		// oldest sample leaves the sorted copy by value
		if (held >= len && held > 0) begin
			leaving = arrivals[oldest];
			pos     = held - 1;
			for (i = 0; i < held; i++) begin
				if (ascending[i] == leaving) begin
					pos = i;
					break;
				end
			end
			for (i = pos; i + 1 < held; i++)
				ascending[i] = ascending[i + 1];
			oldest = (oldest + 1) % MAX_WINDOW;
			held--;
		end
		// newest sample enters both copies
		arrivals[(oldest + held) % MAX_WINDOW] = s;
		pos = held;
		while (pos > 0 && ascending[pos - 1] > s) begin
			ascending[pos] = ascending[pos - 1];
			pos--;
		end
		ascending[pos] = s;
		held++;
		if (held >= len) begin
			k     = (keep_count_reg > len) ? len : int'(keep_count_reg);
			total = '0;
			for (i = 0; i < k; i++)
				total += ascending[i];
			expected_sums.push_back(total[SUM_BITS-1:0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [SUM_BITS-1:0] want;
		if (!arst_n) begin
			held           = 0;
			oldest         = 0;
			window_len_reg = WINDOW_LEN_RESET;
			keep_count_reg = KEEP_COUNT_RESET;
			expected_sums.delete();
			outstanding <= 0;
		end else begin
			// output word against the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("window_sum %0d with nothing expected",
						window_sum));
				end else begin
					want = expected_sums.pop_front();
					sums_checked++;
					if (window_sum !== want)
						report_mismatch($sformatf("window_sum %0d, expected %0d",
							window_sum, want));
				end
			end
			// register writes and read-back
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_WINDOW_LEN) begin
						window_len_reg = pwdata[CFG_BITS-1:0];
						held           = 0;
						oldest         = 0;
					end else if (paddr == ADDR_KEEP_COUNT) begin
						keep_count_reg = pwdata[CFG_BITS-1:0];
					end
				end else if (paddr == ADDR_WINDOW_LEN) begin
					if (prdata[CFG_BITS-1:0] !== window_len_reg)
						report_mismatch($sformatf("window_len reads %0d, expected %0d",
							prdata[CFG_BITS-1:0], window_len_reg));
				end else if (paddr == ADDR_KEEP_COUNT) begin
					if (prdata[CFG_BITS-1:0] !== keep_count_reg)
						report_mismatch($sformatf("keep_count reads %0d, expected %0d",
							prdata[CFG_BITS-1:0], keep_count_reg));
				end
			end
			// accepted input word
			if (in_valid && !in_stall)
				slide_window(sample, restart);
			outstanding <= expected_sums.size();
		end
	end

endmodule

@@ sim/tb_sliding_window_k_smallest_sum.sv @@
// testbench top: stimulus, idling, register writes and verdict for the k-smallest sum filter
module tb_sliding_window_k_smallest_sum;
	import swks_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int SETTLE_CYCLES = TREE_LEVELS + 8;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] sample    = '0;
	logic                   restart   = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [SUM_BITS-1:0]    window_sum;
	logic                   psel      = 1'b0;
	logic                   penable   = 1'b0;
	logic                   pwrite    = 1'b0;
	logic [ADDR_BITS-1:0]   paddr     = '0;
	logic [DATA_BITS-1:0]   pwdata    = '0;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;

	int mismatches;
	int outstanding;
	int sums_checked;
	int snd_idle     = 27;
	int rcv_idle     = 57;
	int words_sent   = 0;
	int reg_writes   = 0;

	sliding_window_k_smallest_sum DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_sum (window_sum),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	swks_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_sum   (window_sum),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.sums_checked (sums_checked)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rcv_idle);

	// hard stop in case the block hangs
	initial begin
		#(CLK_PERIOD * 250000);
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one word, with random gaps before it, and hold it until taken
	task automatic send_word(input logic [SAMPLE_BITS-1:0] s, input logic rs);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= rs;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
	endtask

	// stop sending until every expected sum is out and the pipeline is empty
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register access: setup cycle then access cycle
	task automatic reg_access(input logic which, input logic wr, input logic [DATA_BITS-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {which, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (wr)
			reg_writes++;
	endtask

	task automatic set_window(input int w, input int k);
		settle_idle();
		reg_access(REG_WINDOW_LEN, 1'b1, w);
		reg_access(REG_KEEP_COUNT, 1'b1, k);
		reg_access(REG_WINDOW_LEN, 1'b0, '0);
		reg_access(REG_KEEP_COUNT, 1'b0, '0);
	endtask

	initial begin
		int                     w;
		int                     k;
		int                     live;
		int                     n;
		logic [SAMPLE_BITS-1:0] s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values read back
		reg_access(REG_WINDOW_LEN, 1'b0, '0);
		reg_access(REG_KEEP_COUNT, 1'b0, '0);

		// directed: extremes, duplicates leaving by value, restart
		set_window(3, 2);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h1234, 1'b1);
		send_word(16'h5555, 1'b0);
		send_word(16'hAAAA, 1'b0);
		// same window length written again still empties the window
		settle_idle();
		reg_access(REG_WINDOW_LEN, 1'b1, 3);
		send_word(16'h0007, 1'b0);
		send_word(16'h0003, 1'b0);
		send_word(16'h0005, 1'b0);
		// empty sum, then keep count above the window
		settle_idle();
		reg_access(REG_KEEP_COUNT, 1'b1, 0);
		send_word(16'h7FFF, 1'b0);
		settle_idle();
		reg_access(REG_KEEP_COUNT, 1'b1, 127);
		send_word(16'hFFFE, 1'b0);
		// zero window acts as one
		set_window(0, 127);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);
		// oversized window saturates to the full store
		set_window(127, 127);
		for (int i = 0; i < MAX_WINDOW + 2; i++)
			send_word(16'hFFFF, 1'b0);

		// random: three idling regimes, several settings in each
		for (int regime = 0; regime < 3; regime++) begin
			snd_idle = (regime == 0) ? 27 : (regime == 1) ? 57 : 0;
			rcv_idle = (regime == 0) ? 57 : (regime == 1) ? 27 : 0;
			for (int seg = 0; seg < 6; seg++) begin
				case ($urandom_range(9))
					0:       w = 1;
					1:       w = 2;
					2:       w = MAX_WINDOW;
					3:       w = $urandom_range(MAX_WINDOW + 1, 127);
					4:       w = 0;
					default: w = $urandom_range(3, 16);
				endcase
				live = (w == 0) ? 1 : (w > MAX_WINDOW) ? MAX_WINDOW : w;
				case ($urandom_range(7))
					0:       k = 0;
					1:       k = 127;
					2:       k = MAX_WINDOW;
					3:       k = 1;
					default: k = $urandom_range(1, live + 2);
				endcase
				set_window(w, k);
				n = live + $urandom_range(40, 70);
				for (int i = 0; i < n; i++) begin
					// keep count changed mid-stream, window kept
					if (i == n / 2) begin
						settle_idle();
						reg_access(REG_KEEP_COUNT, 1'b1, $urandom_range(0, live + 1));
					end
					case ($urandom_range(9))
						0:       s = '0;
						1:       s = '1;
						2, 3:    s = SAMPLE_BITS'($urandom_range(7));
						default: s = SAMPLE_BITS'($urandom);
					endcase
					send_word(s, $urandom_range(39) == 0);
				end
			end
		end

		// drain and verdict
		settle_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d words sent over %0d register writes, %0d window sums checked",
			words_sent, reg_writes, sums_checked);
		$display("windows from 1 to %0d, empty and saturated keep counts, restarts",
			MAX_WINDOW);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
